// File: sv/sha256_pkg.sv
package sha256_pkg;

  localparam int WordW = 32;
  localparam int BlockWords = 16;
  localparam int Rounds = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
      6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
      6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
      6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
      6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6A09E667; 3'd1: h = 32'hBB67AE85;
      3'd2: h = 32'h3C6EF372; 3'd3: h = 32'hA54FF53A;
      3'd4: h = 32'h510E527F; 3'd5: h = 32'h9B05688C;
      3'd6: h = 32'h1F83D9AB; 3'd7: h = 32'h5BE0CD19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: sv/sha256_ram.sv
module sha256_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/sha256_core.sv
// One compression: one round per cycle, schedule window rolled in place.
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::core_ctl_t ctl_in,
  input  logic [31:0]           blk_word,
  output logic [3:0]            blk_addr,
  input  logic [255:0]          h_in,
  output logic [255:0]          h_out,
  output sha256_pkg::core_ctl_t ctl_out
);
  import sha256_pkg::*;

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [6:0]  t;
  logic        busy;
  logic        done;
  logic [31:0] wt, s0, s1, ch, maj, t1, t2, es1, as0;
  logic [5:0]  rnd;

  assign rnd = t[5:0];
  // the RAM address for the next round's block word is issued during the current round, as the RAM read is registered
  assign blk_addr = (busy && t < 7'd16) ? 4'(t + 7'd1) : 4'd0;

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wt = (t < 7'd16) ? blk_word : (s1 + w[9] + s0 + w[0]);
    es1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + es1 + ch + round_k(rnd) + wt;
    as0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = as0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      t <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
        t <= '0;
      end else if (busy) begin
        t <= t + 7'd1;
        if (t == 7'(Rounds - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      for (int i = 0; i < 8; i++) v[i] <= h_in[255 - 32*i -: 32];
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) h_out[255 - 32*i -: 32] = h_in[255 - 32*i -: 32] + v[i];
  end

  assign ctl_out.start = 1'b0;
  assign ctl_out.busy = busy;
  assign ctl_out.done = done;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("done without run");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !ctl_in.start)
    else $error("start while busy");
`endif
endmodule

// File: sv/sha256_stream_hasher_top.sv
// SHA-256 over a byte stream.
// Input channel (in_valid/in_stall): action 0 adds data_byte to the
// message; action 1 finishes the message. Output channel
// (out_valid/out_stall) carries the eight digest words, word_index 0..7,
// last_word on the eighth.
// Add items are taken one per cycle while a block gathers. The 64th byte
// of a block starts a compression (load, 64 rounds, add; one round per
// cycle in the shared round unit); in_stall stays high during it.
// A finish writes 16 pad words per padded block and runs one or two
// compressions, then emits the words one per cycle while out_stall is
// low; the input channel is stalled until the last word is taken.
// Bytes are kept as 32-bit words in a 16-entry RAM.
// A stall on the output holds the current word; nothing else advances.
// Reset (rst, synchronous) restores the initial hash values and clears the
// byte count and bit length. After each digest the block restarts the same
// way for a new message.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  state_t state, state_next;
  logic [255:0] h, h_new;
  logic [5:0]   fill;
  logic [63:0]  mbits;
  logic [31:0]  acc;          // word being gathered
  logic         finishing;    // padding a finish
  logic         len_done;     // length block was compressed
  logic [4:0]   pad_idx;      // pad word counter
  logic [2:0]   emit_idx;
  logic         in_acc;
  core_ctl_t    cin, cout;

  logic         ram_we;
  logic [3:0]   ram_waddr, ram_raddr, core_addr;
  logic [31:0]  ram_wdata, ram_rdata;
  logic [31:0]  pad_word;
  logic         second_needed;

  assign in_acc = in_valid && !in_stall;
  assign second_needed = (fill > 6'd55);

  sha256_ram #(.Width(WordW), .Depth(BlockWords)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  sha256_core u_core (
    .clk, .rst, .ctl_in(cin), .blk_word(ram_rdata), .blk_addr(core_addr),
    .h_in(h), .h_out(h_new), .ctl_out(cout)
  );

  // padded word: bytes before fill stay, 0x80 at fill, zeros after,
  // length in words 14 and 15 of the final block; kept bytes come from
  // the partial word or from the RAM word read for this pad index
  always_comb begin
    logic [31:0] wv;
    logic [31:0] src;
    logic [5:0]  bpos;
    wv = '0;
    src = (pad_idx[3:0] == fill[5:2]) ? acc : ram_rdata;
    for (int b = 0; b < 4; b++) begin
      bpos = {pad_idx[3:0], 2'(b)};
      if (pad_idx[4]) begin
        wv[31 - 8*b -: 8] = 8'h00;
      end else if (bpos < fill) begin
        wv[31 - 8*b -: 8] = src[31 - 8*b -: 8];
      end else if (bpos == fill) begin
        wv[31 - 8*b -: 8] = 8'h80;
      end
    end
    pad_word = wv;
    if (!second_needed || pad_idx[4]) begin
      if (pad_idx[3:0] == 4'd14) pad_word = mbits[63:32];
      if (pad_idx[3:0] == 4'd15) pad_word = mbits[31:0];
    end
  end

  // pad_idx[4] marks the second pad block (zeros plus the length words)
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && action) state_next = ST_PAD;
        else if (in_acc && fill == 6'd63) state_next = ST_LOAD;
      end
      ST_PAD:  if (pad_idx[3:0] == 4'd15) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: if (cout.done) state_next = ST_ADD;
      ST_ADD: begin
        if (!finishing) state_next = ST_IDLE;
        else if (len_done) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT: if (!out_stall && emit_idx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_EMIT);
    cin.start = (state == ST_LOAD);
    cin.busy = 1'b0;
    cin.done = 1'b0;
    ram_we = 1'b0;
    ram_waddr = fill[5:2];
    ram_wdata = {acc[31:8], data_byte};
    case (state)
      ST_IDLE: begin
        ram_we = in_acc && !action && fill[1:0] == 2'd3;
        case (fill[1:0])
          2'd0: ram_wdata = {data_byte, 24'h0};
          2'd1: ram_wdata = {acc[31:24], data_byte, 16'h0};
          2'd2: ram_wdata = {acc[31:16], data_byte, 8'h0};
          default: ram_wdata = {acc[31:8], data_byte};
        endcase
      end
      ST_PAD: begin
        ram_we = 1'b1;
        ram_waddr = pad_idx[3:0];
        ram_wdata = pad_word;
      end
      default: ram_we = 1'b0;
    endcase
    ram_raddr = (state == ST_LOAD) ? 4'd0 : core_addr;
    if (state == ST_PAD && !pad_idx[4]) begin
      // the first pad block keeps earlier words; read them to merge
      ram_raddr = 4'(pad_idx[3:0] + 4'd1);
    end
  end

  // acc holds the partial word being gathered; padding merges it with the
  // RAM words read one index ahead
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      mbits <= '0;
      finishing <= 1'b0;
      len_done <= 1'b0;
      pad_idx <= '0;
      emit_idx <= '0;
      for (int i = 0; i < 8; i++) h[255 - 32*i -: 32] <= init_h(3'(i));
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_acc && !action) begin
            fill <= fill + 6'd1;
            mbits <= mbits + 64'd8;
          end else if (in_acc && action) begin
            finishing <= 1'b1;
            len_done <= !second_needed;
            pad_idx <= '0;
          end
        end
        ST_PAD: pad_idx <= pad_idx + 5'd1;
        ST_ADD: begin
          h <= h_new;
          if (finishing && !len_done) begin
            len_done <= 1'b1;
            pad_idx <= 5'h10;
          end
          if (finishing && len_done) emit_idx <= '0;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[255 - 32*i -: 32] <= init_h(3'(i));
              fill <= '0;
              mbits <= '0;
              finishing <= 1'b0;
              len_done <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // gather bytes of the partial word
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc && !action) begin
      acc <= ram_wdata;
    end
  end

  assign digest_word = h[255 - 32*emit_idx -: 32];
  assign word_index = emit_idx;
  assign last_word = (emit_idx == 3'd7);

`ifndef SYNTHESIS
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(emit_idx))
    else $error("digest word dropped");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    cout.busy |-> in_stall)
    else $error("input taken while compressing");
  a_emit_no_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !cout.busy)
    else $error("emit during compression");
`endif
endmodule
